@@ rtl/json_string_unescape_utf8_macros.svh @@
// assertion macros shared by the json string unescape rtl
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// same-cycle implication, checked while out of reset
`define JSU_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// next-cycle implication, checked while out of reset
`define JSU_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

@@ rtl/jsu_pkg.sv @@
// types, character codes and utf-8 encoder for the json string unescape block
`default_nettype none
package jsu_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;

    typedef enum logic [6:0] {
        MODE_IDLE   = 7'b0000001,
        MODE_STR    = 7'b0000010,
        MODE_ESC    = 7'b0000100,
        MODE_HEXA   = 7'b0001000,
        MODE_HIGH   = 7'b0010000,
        MODE_HIGHBS = 7'b0100000,
        MODE_HEXB   = 7'b1000000
    } mode_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_HT = 8'h09;

    localparam logic [15:0] SUR_HI_MIN = 16'hD800;
    localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

    localparam logic [CP_W-1:0] LIM_1B = 21'h80;
    localparam logic [CP_W-1:0] LIM_2B = 21'h800;
    localparam logic [CP_W-1:0] LIM_3B = 21'h10000;
    localparam logic [7:0] LEAD_2B = 8'hC0;
    localparam logic [7:0] LEAD_3B = 8'hE0;
    localparam logic [7:0] LEAD_4B = 8'hF0;
    localparam logic [7:0] CONT_B  = 8'h80;

    typedef struct packed {
        logic [1:0]                   last_idx;
        logic [3:0][BYTE_W-1:0]       bytes;
    } enc_t;

    function automatic enc_t utf8_enc(input logic [CP_W-1:0] cp);
        enc_t e;
        e.bytes = '0;
        if (cp < LIM_1B) begin
            e.last_idx = 2'd0;
            e.bytes[0] = cp[7:0];
        end else if (cp < LIM_2B) begin
            e.last_idx = 2'd1;
            e.bytes[0] = LEAD_2B | {3'b000, cp[10:6]};
            e.bytes[1] = CONT_B | {2'b00, cp[5:0]};
        end else if (cp < LIM_3B) begin
            e.last_idx = 2'd2;
            e.bytes[0] = LEAD_3B | {4'b0000, cp[15:12]};
            e.bytes[1] = CONT_B | {2'b00, cp[11:6]};
            e.bytes[2] = CONT_B | {2'b00, cp[5:0]};
        end else begin
            e.last_idx = 2'd3;
            e.bytes[0] = LEAD_4B | {5'b00000, cp[20:18]};
            e.bytes[1] = CONT_B | {2'b00, cp[17:12]};
            e.bytes[2] = CONT_B | {2'b00, cp[11:6]};
            e.bytes[3] = CONT_B | {2'b00, cp[5:0]};
        end
        return e;
    endfunction

endpackage
`default_nettype wire

@@ rtl/json_string_unescape_utf8.sv @@
// json string literal unescape with utf-16 escape to utf-8 conversion
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | s_in_byte
//  m_      | out | m_valid / m_ready  | m_out_byte, m_kind, m_last
//
// one raw byte is decoded per cycle, while s_ready is high, into a result
// bundle of up to four bytes; the bundle drains one result per cycle while
// m_ready is high and holds the input side until its last result is taken;
// bytes with no result (backslash, hex digits, opening quote) leave it empty
// s_ready is high when the bundle is empty or its last result is being taken
// reset (aresetn low, synchronous) returns to idle and empties the bundle
`default_nettype none
module json_string_unescape_utf8 (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire logic [7:0]            s_in_byte,
    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output      logic [7:0]            m_out_byte,
    output      logic [1:0]            m_kind,
    output      logic                  m_last
);
    import jsu_pkg::*;

    `include "json_string_unescape_utf8_macros.svh"

    mode_t        mode_reg, mode_next;
    logic [15:0]  accum_reg, accum_next;
    logic [1:0]   hcnt_reg, hcnt_next;
    logic         hbad_reg, hbad_next;
    logic [9:0]   half_reg, half_next;

    logic         bund_valid_reg;
    logic [1:0]   idx_reg;
    logic [1:0]   last_idx_reg;
    kind_t        kind_reg;
    logic [3:0][7:0] bytes_reg;

    logic         accept, pop;
    logic [7:0]   b;

    // plain string byte path
    mode_t        sb_mode;
    logic         sb_has;
    kind_t        sb_kind;
    logic [7:0]   sb_byte;

    // escaped byte path
    mode_t        eb_mode;
    logic         eb_has;
    kind_t        eb_kind;
    logic [7:0]   eb_byte;
    logic         eb_start_u;

    logic         hex_ok;
    logic [3:0]   hex_val;
    logic [15:0]  unit_acc;
    logic [15:0]  unit;
    logic         hbad_new;
    logic         unit_lo, unit_hi;
    logic [CP_W-1:0] pair_cp;
    logic [CP_W-1:0] enc_cp;
    enc_t         enc;

    logic         res_has;
    kind_t        res_kind;
    logic [1:0]   res_last_idx;
    logic [3:0][7:0] res_bytes;
    logic         res_use_enc;

    assign b       = s_in_byte;
    assign m_valid = bund_valid_reg;
    assign m_last  = (idx_reg == last_idx_reg);
    assign m_kind  = kind_reg;
    assign m_out_byte = bytes_reg[idx_reg];
    assign pop     = m_valid && m_ready;
    assign s_ready = !bund_valid_reg || (m_ready && m_last);
    assign accept  = s_valid && s_ready;

    always_comb begin
        sb_mode = MODE_STR;
        sb_has  = 1'b1;
        sb_kind = KIND_DATA;
        sb_byte = b;
        if (b == CH_QUOTE) begin
            sb_mode = MODE_IDLE;
            sb_kind = KIND_END;
            sb_byte = '0;
        end else if (b == CH_NUL) begin
            sb_mode = MODE_IDLE;
            sb_kind = KIND_ERR;
            sb_byte = '0;
        end else if (b == CH_BSL) begin
            sb_mode = MODE_ESC;
            sb_has  = 1'b0;
        end
    end

    always_comb begin
        eb_mode    = MODE_STR;
        eb_has     = 1'b1;
        eb_kind    = KIND_DATA;
        eb_byte    = b;
        eb_start_u = 1'b0;
        case (b)
            CH_NUL: begin
                eb_mode = MODE_IDLE;
                eb_kind = KIND_ERR;
                eb_byte = '0;
            end
            CH_B: eb_byte = CTL_BS;
            CH_F: eb_byte = CTL_FF;
            CH_N: eb_byte = CTL_LF;
            CH_R: eb_byte = CTL_CR;
            CH_T: eb_byte = CTL_HT;
            CH_U: begin
                eb_mode    = MODE_HEXA;
                eb_has     = 1'b0;
                eb_start_u = 1'b1;
            end
            default: eb_byte = b;
        endcase
    end

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = '0;
        if (b inside {[8'h30:8'h39]}) begin
            hex_val = b[3:0];
        end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            hex_val = b[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign unit_acc = {accum_reg[11:0], hex_val};
    assign hbad_new = hbad_reg || !hex_ok;
    assign unit     = hbad_new ? 16'h0000 : unit_acc;
    assign unit_lo  = (unit >= SUR_LO_MIN) && (unit <= SUR_LO_MAX);
    assign unit_hi  = (unit >= SUR_HI_MIN) && (unit <= SUR_HI_MAX);
    assign pair_cp  = SUPP_BASE + {1'b0, half_reg, unit[9:0]};
    assign enc_cp   = (mode_reg == MODE_HEXB) ? pair_cp : {5'b00000, unit};
    assign enc      = utf8_enc(enc_cp);

    always_comb begin
        mode_next    = mode_reg;
        accum_next   = accum_reg;
        hcnt_next    = hcnt_reg;
        hbad_next    = hbad_reg;
        half_next    = half_reg;
        res_has      = 1'b0;
        res_kind     = KIND_DATA;
        res_last_idx = 2'd0;
        res_bytes    = '0;
        res_use_enc  = 1'b0;
        case (mode_reg)
            MODE_IDLE: begin
                if (b == CH_QUOTE) begin
                    mode_next = MODE_STR;
                end else begin
                    res_has  = 1'b1;
                    res_kind = KIND_ERR;
                end
            end
            MODE_STR: begin
                mode_next    = sb_mode;
                res_has      = sb_has;
                res_kind     = sb_kind;
                res_bytes[0] = sb_byte;
            end
            MODE_ESC: begin
                mode_next    = eb_mode;
                res_has      = eb_has;
                res_kind     = eb_kind;
                res_bytes[0] = eb_byte;
                if (eb_start_u) begin
                    accum_next = '0;
                    hcnt_next  = '0;
                    hbad_next  = 1'b0;
                end
            end
            MODE_HEXA, MODE_HEXB: begin
                if (b == CH_NUL || b == CH_QUOTE) begin
                    mode_next    = sb_mode;
                    res_has      = sb_has;
                    res_kind     = sb_kind;
                    res_bytes[0] = sb_byte;
                end else begin
                    accum_next = unit_acc;
                    hbad_next  = hbad_new;
                    if (hcnt_reg == 2'd3) begin
                        hcnt_next = '0;
                        mode_next = MODE_STR;
                        if (mode_reg == MODE_HEXA) begin
                            // zero and lone low surrogates vanish
                            if (unit_hi) begin
                                half_next = unit[9:0];
                                mode_next = MODE_HIGH;
                            end else if (unit != 16'h0000 && !unit_lo) begin
                                res_use_enc = 1'b1;
                            end
                        end else if (unit_lo) begin
                            res_use_enc = 1'b1;
                        end
                    end else begin
                        hcnt_next = hcnt_reg + 2'd1;
                    end
                end
            end
            MODE_HIGH: begin
                if (b == CH_BSL) begin
                    mode_next = MODE_HIGHBS;
                end else begin
                    mode_next    = sb_mode;
                    res_has      = sb_has;
                    res_kind     = sb_kind;
                    res_bytes[0] = sb_byte;
                end
            end
            MODE_HIGHBS: begin
                if (b == CH_U) begin
                    mode_next  = MODE_HEXB;
                    accum_next = '0;
                    hcnt_next  = '0;
                    hbad_next  = 1'b0;
                end else begin
                    mode_next    = eb_mode;
                    res_has      = eb_has;
                    res_kind     = eb_kind;
                    res_bytes[0] = eb_byte;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase
        if (res_use_enc) begin
            res_has      = 1'b1;
            res_kind     = KIND_DATA;
            res_last_idx = enc.last_idx;
            res_bytes    = enc.bytes;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            bund_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end else begin
            if (accept) begin
                mode_reg       <= mode_next;
                bund_valid_reg <= res_has;
                idx_reg        <= '0;
            end else if (pop) begin
                if (m_last) begin
                    bund_valid_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            accum_reg    <= accum_next;
            hcnt_reg     <= hcnt_next;
            hbad_reg     <= hbad_next;
            half_reg     <= half_next;
            last_idx_reg <= res_last_idx;
            kind_reg     <= res_kind;
            bytes_reg    <= res_bytes;
        end
    end

    // a new request only lands when the old bundle leaves in the same cycle
    `JSU_ASSERT_IMP(a_no_overwrite, aclk, aresetn, accept && bund_valid_reg, m_ready && m_last)
    `JSU_ASSERT_IMP(a_idx_in_range, aclk, aresetn, bund_valid_reg, idx_reg <= last_idx_reg)
    `JSU_ASSERT_IMP(a_ctrl_single, aclk, aresetn, bund_valid_reg && kind_reg != KIND_DATA, last_idx_reg == 2'd0)
    `JSU_ASSERT_NXT(a_idx_step, aclk, aresetn, pop && !m_last, bund_valid_reg && idx_reg == $past(idx_reg) + 2'd1)

endmodule
`default_nettype wire

@@ tb/json_string_unescape_utf8_tb.sv @@
// self-checking testbench for the json string unescape block with utf-8 output
`timescale 1ns / 1ps
module json_string_unescape_utf8_tb;
    import jsu_pkg::*;

    localparam int N_DIRECTED  = 28;
    localparam int PHASE_BYTES = 75;
    localparam int HOLD_LEN    = 80;
    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } result_t;

    typedef struct {
        logic [7:0] stim;
        bit         typed;
        int         typed_n;
        logic [7:0] typed_data;
        kind_t      typed_kind;
    } stim_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic [1:0] m_kind;
    logic       m_last;

    json_string_unescape_utf8 DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_kind     (m_kind),
        .m_last     (m_last)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // decoder state mirrored by the predictor
    mode_t       dec_mode = MODE_IDLE;
    logic [15:0] dec_accum = '0;
    logic [1:0]  dec_digits = '0;
    logic        dec_bad = 1'b0;
    logic [9:0]  dec_high = '0;

    result_t res_buf [4];
    int      res_n;
    result_t decoded_q [$];
    logic [7:0] plan_q [$];

    int fail_count = 0;
    int item_count = 0;
    int out_count = 0;
    int end_count = 0;
    int err_count = 0;
    int pair_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{"A",      1, 1, 8'h00, KIND_ERR},   // not a quote while idle
        '{CH_QUOTE, 1, 0, 8'h00, KIND_DATA},
        '{8'hFF,    1, 1, 8'hFF, KIND_DATA},
        '{CH_BSL,   0, 0, 8'h00, KIND_DATA},
        '{CH_U,     0, 0, 8'h00, KIND_DATA},
        '{"D",      0, 0, 8'h00, KIND_DATA},
        '{"8",      0, 0, 8'h00, KIND_DATA},
        '{"0",      0, 0, 8'h00, KIND_DATA},
        '{"0",      0, 0, 8'h00, KIND_DATA},
        '{"x",      0, 0, 8'h00, KIND_DATA},  // held high half dropped
        '{CH_BSL,   0, 0, 8'h00, KIND_DATA},
        '{CH_U,     0, 0, 8'h00, KIND_DATA},
        '{"d",      0, 0, 8'h00, KIND_DATA},
        '{"b",      0, 0, 8'h00, KIND_DATA},
        '{"f",      0, 0, 8'h00, KIND_DATA},
        '{"f",      0, 0, 8'h00, KIND_DATA},
        '{CH_BSL,   0, 0, 8'h00, KIND_DATA},
        '{CH_U,     0, 0, 8'h00, KIND_DATA},
        '{"D",      0, 0, 8'h00, KIND_DATA},
        '{"F",      0, 0, 8'h00, KIND_DATA},
        '{"F",      0, 0, 8'h00, KIND_DATA},
        '{"F",      0, 0, 8'h00, KIND_DATA},  // top code point, four bytes
        '{CH_BSL,   0, 0, 8'h00, KIND_DATA},
        '{CH_U,     0, 0, 8'h00, KIND_DATA},
        '{CH_QUOTE, 1, 1, 8'h00, KIND_END},   // quote cuts the escape short
        '{CH_NUL,   1, 1, 8'h00, KIND_ERR},
        '{CH_QUOTE, 1, 0, 8'h00, KIND_DATA},
        '{CH_NUL,   1, 1, 8'h00, KIND_ERR}
    };

    function automatic void emit(input logic [7:0] data, input kind_t kind);
        res_buf[res_n].data = data;
        res_buf[res_n].kind = kind;
        res_buf[res_n].last = 1'b0;
        res_n++;
        if (kind == KIND_END) end_count++;
        if (kind == KIND_ERR) err_count++;
    endfunction

    function automatic void reset_decoder();
        dec_mode = MODE_IDLE;
        dec_accum = '0;
        dec_digits = '0;
        dec_bad = 1'b0;
        dec_high = '0;
    endfunction

    function automatic void start_unit(input mode_t next_mode);
        dec_mode = next_mode;
        dec_accum = '0;
        dec_digits = '0;
        dec_bad = 1'b0;
    endfunction

    function automatic logic [4:0] hex_digit_value(input logic [7:0] b);
        if (b >= "0" && b <= "9") return 5'(b - "0");
        if (b >= "A" && b <= "F") return 5'(b - "A" + 8'd10);
        if (b >= "a" && b <= "f") return 5'(b - "a" + 8'd10);
        return 5'h10;
    endfunction

    function automatic void encode_cp(input logic [20:0] cp);
        if (cp < LIM_1B) begin
            emit(cp[7:0], KIND_DATA);
        end else if (cp < LIM_2B) begin
            emit(LEAD_2B | 8'(cp[10:6]), KIND_DATA);
            emit(CONT_B | 8'(cp[5:0]), KIND_DATA);
        end else if (cp < LIM_3B) begin
            emit(LEAD_3B | 8'(cp[15:12]), KIND_DATA);
            emit(CONT_B | 8'(cp[11:6]), KIND_DATA);
            emit(CONT_B | 8'(cp[5:0]), KIND_DATA);
        end else begin
            emit(LEAD_4B | 8'(cp[20:18]), KIND_DATA);
            emit(CONT_B | 8'(cp[17:12]), KIND_DATA);
            emit(CONT_B | 8'(cp[11:6]), KIND_DATA);
            emit(CONT_B | 8'(cp[5:0]), KIND_DATA);
        end
    endfunction

    function automatic void take_string_byte(input logic [7:0] b);
        if (b == CH_QUOTE) begin
            emit(8'h00, KIND_END);
            reset_decoder();
        end else if (b == CH_NUL) begin
            emit(8'h00, KIND_ERR);
            reset_decoder();
        end else if (b == CH_BSL) begin
            dec_mode = MODE_ESC;
        end else begin
            emit(b, KIND_DATA);
            dec_mode = MODE_STR;
        end
    endfunction

    function automatic void take_escape(input logic [7:0] b);
        dec_mode = MODE_STR;
        case (b)
            CH_NUL: begin
                emit(8'h00, KIND_ERR);
                reset_decoder();
            end
            CH_B: emit(CTL_BS, KIND_DATA);
            CH_F: emit(CTL_FF, KIND_DATA);
            CH_N: emit(CTL_LF, KIND_DATA);
            CH_R: emit(CTL_CR, KIND_DATA);
            CH_T: emit(CTL_HT, KIND_DATA);
            CH_U: start_unit(MODE_HEXA);
            default: emit(b, KIND_DATA);
        endcase
    endfunction

    // fills res_buf with the results one raw byte causes
    function automatic void decode_byte(input logic [7:0] b);
        logic [4:0]  v;
        logic [15:0] unit;
        res_n = 0;
        case (dec_mode)
            MODE_IDLE: begin
                if (b == CH_QUOTE) dec_mode = MODE_STR;
                else emit(8'h00, KIND_ERR);
            end
            MODE_STR: take_string_byte(b);
            MODE_ESC: take_escape(b);
            MODE_HEXA, MODE_HEXB: begin
                if (b == CH_NUL || b == CH_QUOTE) begin
                    take_string_byte(b);
                end else begin
                    v = hex_digit_value(b);
                    if (v[4]) dec_bad = 1'b1;
                    dec_accum = {dec_accum[11:0], v[3:0]};
                    if (dec_digits != 2'd3) begin
                        dec_digits++;
                    end else begin
                        unit = dec_bad ? 16'h0000 : dec_accum;
                        dec_digits = '0;
                        if (dec_mode == MODE_HEXA) begin
                            dec_mode = MODE_STR;
                            if (unit >= SUR_HI_MIN && unit <= SUR_HI_MAX) begin
                                dec_high = unit[9:0];
                                dec_mode = MODE_HIGH;
                            end else if (unit != 16'h0000 && !(unit >= SUR_LO_MIN
                                         && unit <= SUR_LO_MAX)) begin
                                encode_cp({5'b0, unit});
                            end
                        end else begin
                            dec_mode = MODE_STR;
                            if (unit >= SUR_LO_MIN && unit <= SUR_LO_MAX) begin
                                encode_cp(SUPP_BASE + 21'({dec_high, unit[9:0]}));
                                pair_count++;
                            end
                        end
                    end
                end
            end
            MODE_HIGH: begin
                if (b == CH_BSL) dec_mode = MODE_HIGHBS;
                else take_string_byte(b);
            end
            MODE_HIGHBS: begin
                if (b == CH_U) start_unit(MODE_HEXB);
                else take_escape(b);
            end
            default: reset_decoder();
        endcase
        if (res_n > 0) res_buf[res_n - 1].last = 1'b1;
    endfunction

    // random text generation

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSL);
        return b;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] b;
        logic [4:0] v;
        do begin
            b = 8'($urandom_range(1, 255));
            v = hex_digit_value(b);
        end while (!v[4] || b == CH_QUOTE);
        return b;
    endfunction

    // any escaped byte except u and nul
    function automatic logic [7:0] escape_char();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0: b = CH_B;
            1: b = CH_F;
            2: b = CH_N;
            3: b = CH_R;
            4: b = CH_T;
            default: do b = 8'($urandom_range(1, 255)); while (b == CH_U);
        endcase
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + {4'h0, v};
        return ($urandom_range(1) ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
    endfunction

    // 0..2 plain code units by utf-8 length, 3 zero, 4 low half, 5 high half
    function automatic logic [15:0] pick_unit(input int cls);
        case (cls)
            0: return 16'($urandom_range(1, 16'h7F));
            1: return 16'($urandom_range(16'h80, 16'h7FF));
            2: return $urandom_range(1) ? 16'($urandom_range(16'h800, 16'hD7FF))
                                        : 16'($urandom_range(16'hE000, 16'hFFFF));
            3: return 16'h0000;
            4: return 16'($urandom_range(SUR_LO_MIN, SUR_LO_MAX));
            default: return 16'($urandom_range(SUR_HI_MIN, SUR_HI_MAX));
        endcase
    endfunction

    function automatic void push_unit(input logic [15:0] unit, input bit spoil);
        int bad_pos;
        bad_pos = $urandom_range(0, 3);
        plan_q.push_back(CH_BSL);
        plan_q.push_back(CH_U);
        for (int i = 0; i < 4; i++) begin
            if (spoil && i == bad_pos) plan_q.push_back(non_hex_char());
            else plan_q.push_back(hex_char(unit[15 - 4 * i -: 4]));
        end
    endfunction

    // returns 1 when the piece ended the string
    function automatic bit push_piece();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            plan_q.push_back(plain_char());
        end else if (pick < 45) begin
            plan_q.push_back(CH_BSL);
            plan_q.push_back(escape_char());
        end else if (pick < 68) begin
            push_unit(pick_unit($urandom_range(0, 2)), $urandom_range(0, 9) == 0);
        end else if (pick < 76) begin
            push_unit(pick_unit($urandom_range(3, 4)), 1'b0);
        end else if (pick < 94) begin
            push_unit(pick_unit(5), 1'b0);
            case ($urandom_range(0, 5))
                0, 1, 2: push_unit(pick_unit(4), $urandom_range(0, 9) == 0);
                3: plan_q.push_back(plain_char());
                4: begin
                    plan_q.push_back(CH_BSL);
                    plan_q.push_back(escape_char());
                end
                default: push_unit(pick_unit($urandom_range(0, 2)), 1'b0);
            endcase
        end else begin
            // escape cut short by a quote or a nul
            if ($urandom_range(1)) begin
                push_unit(pick_unit(5), 1'b0);
                if ($urandom_range(1)) plan_q.push_back(CH_BSL);
            end else begin
                plan_q.push_back(CH_BSL);
                plan_q.push_back(CH_U);
                repeat ($urandom_range(0, 3)) plan_q.push_back(hex_char(4'($urandom())));
            end
            plan_q.push_back($urandom_range(0, 3) == 0 ? CH_NUL : CH_QUOTE);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void push_string();
        int ending;
        if ($urandom_range(0, 9) == 0) begin
            // stray bytes with no opening quote
            repeat ($urandom_range(1, 3)) plan_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        plan_q.push_back(CH_QUOTE);
        repeat ($urandom_range(1, 6)) begin
            if (push_piece()) return;
        end
        ending = $urandom_range(0, 19);
        if (ending == 0) plan_q.push_back(CH_NUL);
        else if (ending != 1) plan_q.push_back(CH_QUOTE);
    endfunction

    // called and returns at a falling edge
    task automatic offer_byte(input logic [7:0] b, input bit typed, input int typed_n,
                              input logic [7:0] typed_data, input kind_t typed_kind);
        result_t r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_byte(b);
        if (typed) begin
            r.data = typed_data;
            r.kind = typed_kind;
            r.last = 1'b1;
            for (int i = 0; i < typed_n; i++) decoded_q.push_back(r);
        end else begin
            for (int i = 0; i < res_n; i++) decoded_q.push_back(res_buf[i]);
        end
        item_count++;
        @(negedge aclk);
    endtask

    task automatic send_plan();
        while (plan_q.size() > 0) offer_byte(plan_q.pop_front(), 1'b0, 0, 8'h00, KIND_DATA);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (decoded_q.size() != 0) @(negedge aclk);
    endtask

    initial begin
        int phase_start;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 8;
        recv_idle_pct = 72;
        for (int i = 0; i < N_DIRECTED; i++) begin
            offer_byte(directed_rows[i].stim, directed_rows[i].typed,
                       directed_rows[i].typed_n, directed_rows[i].typed_data,
                       directed_rows[i].typed_kind);
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 72 : 0;
            recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 8 : 0;
            // long receiver hold-off while requests keep coming
            if (phase == 2) hold_asks++;
            phase_start = item_count;
            while (item_count - phase_start < PHASE_BYTES) begin
                push_string();
                send_plan();
                if ($urandom_range(0, 7) == 0) drain_results();
            end
            drain_results();
        end

        repeat (10) @(posedge aclk);
        $display("%0d request bytes in, %0d results out: %0d strings closed, %0d format errors,",
                 item_count, out_count, end_count, err_count);
        $display("%0d surrogate pairs, across sender-idle, receiver-idle and back-to-back phases",
                 pair_count);
        if (fail_count == 0) begin
            $display("[json_string_unescape_utf8] OK");
        end else begin
            $display("[json_string_unescape_utf8] ERROR");
        end
        $finish;
    end

    always @(negedge aclk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            out_count++;
            if (decoded_q.size() == 0) begin
                $display("%0t: result with nothing expected, actual byte %h kind %0d last %b",
                         $time, m_out_byte, m_kind, m_last);
                fail_count++;
            end else begin
                want = decoded_q.pop_front();
                if (m_out_byte !== want.data) begin
                    $display("%0t: out_byte expected %h actual %h", $time, want.data, m_out_byte);
                    fail_count++;
                end
                if (m_kind !== want.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, m_kind);
                    fail_count++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, decoded_q.size());
            $display("[json_string_unescape_utf8] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/jsu_pkg.sv
rtl/json_string_unescape_utf8.sv
tb/json_string_unescape_utf8_tb.sv
